FILE: rtl/core/led_pkg.sv
// Shared types and constants of the line editing block.
`timescale 1ns / 1ps

package led_pkg;

    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 3;
    localparam int CFG_IDX_W = 8;

    // Display action codes.
    localparam logic [ACTION_W-1:0] ACT_ECHO  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ERASE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WRAP  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_BELL  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_END   = 3'd4;

    // Character classes.
    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_LOW  = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'd126;

    // Register indexes and their reset values.
    localparam logic [CFG_IDX_W-1:0] REG_ERASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KILL  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END   = 8'd3;

    localparam logic [BYTE_W-1:0] RST_ERASE = 8'd127;
    localparam logic [BYTE_W-1:0] RST_KILL  = 8'd21;
    localparam logic [BYTE_W-1:0] RST_WORD  = 8'd23;
    localparam logic [BYTE_W-1:0] RST_END   = 8'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] erase_code;
        logic [BYTE_W-1:0] kill_code;
        logic [BYTE_W-1:0] word_erase_code;
        logic [BYTE_W-1:0] end_code;
    } led_cfg_t;

    typedef struct packed {
        logic                valid;
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   out_byte;
        logic                last;
    } led_emit_t;

    typedef struct packed {
        logic busy;
        logic finished;
    } led_status_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_KILL   = 8'b0000_0100,
        S_WREAD  = 8'b0000_1000,
        S_WCHK   = 8'b0001_0000,
        S_WFLUSH = 8'b0010_0000,
        S_WRAP   = 8'b0100_0000,
        S_BELL   = 8'b1000_0000
    } led_state_t;

endpackage

FILE: rtl/core/led_line_mem.sv
// Line buffer memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module led_line_mem #(
    parameter int DEPTH = 40,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/led_ctrl.sv
// Line editing sequencer with the shared cursor step unit.
`timescale 1ns / 1ps

module led_ctrl #(
    parameter int LINE_LENGTH = 40,
    parameter int CW          = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  led_pkg::led_cfg_t      cfg,
    output led_pkg::led_emit_t     emit,
    input  logic                   emit_ready,
    output logic                   wr_en,
    output logic [CW-1:0]          wr_addr,
    output logic [7:0]             wr_data,
    output logic                   rd_en,
    output logic [CW-1:0]          rd_addr,
    input  logic [7:0]             rd_data,
    output led_pkg::led_status_t   status,
    output logic [CW-1:0]          cursor
);

    import led_pkg::*;

    led_state_t      state_reg, state_next;
    logic [7:0]      byte_reg, byte_next;
    logic [CW-1:0]   cursor_reg, cursor_next;
    logic            finished_reg, finished_next;
    logic            phase_reg, phase_next;
    logic            pending_reg, pending_next;

    logic            hit_end, hit_erase, hit_kill, hit_word, is_print, take_print;
    logic            step_dec;
    logic [CW:0]     step_sum;
    logic            cur_zero, cur_one, wrap_full;
    logic            not_space, go_on;

    // Decode of the held byte against the edit codes, in priority order.
    assign cur_zero  = (cursor_reg == '0);
    assign hit_end   = (byte_reg == cfg.end_code) && cur_zero;
    assign hit_erase = (byte_reg == cfg.erase_code);
    assign hit_kill  = (byte_reg == cfg.kill_code);
    assign hit_word  = (byte_reg == cfg.word_erase_code);
    assign is_print  = (byte_reg >= PRINT_LOW) && (byte_reg <= PRINT_HIGH);
    assign take_print = is_print && !hit_end && !hit_erase && !hit_kill && !hit_word;

    // The one cursor adder: increments for an echo, decrements everywhere else.
    assign step_dec  = !((state_reg == S_DECIDE) && take_print);
    assign step_sum  = {1'b0, cursor_reg} + (step_dec ? {(CW+1){1'b1}} : (CW+1)'(1));
    assign cur_one   = (step_sum[CW-1:0] == '0);
    assign wrap_full = (step_sum == (CW+1)'(LINE_LENGTH));

    assign not_space = (rd_data != SPACE_CHAR);
    assign go_on     = !phase_reg || not_space;

    assign rd_addr = step_sum[CW-1:0];
    assign wr_addr = cursor_reg;
    assign wr_data = byte_reg;

    always_comb
    begin
        state_next    = state_reg;
        byte_next     = byte_reg;
        cursor_next   = cursor_reg;
        finished_next = finished_reg;
        phase_next    = phase_reg;
        pending_next  = pending_reg;
        emit          = '0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = in_byte;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (finished_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (hit_end)
                begin
                    emit = '{valid: 1'b1, action: ACT_END, out_byte: '0, last: 1'b1};
                    if (emit_ready)
                    begin
                        finished_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (hit_erase)
                begin
                    if (cur_zero)
                    begin
                        state_next = S_BELL;
                    end
                    else
                    begin
                        emit = '{valid: 1'b1, action: ACT_ERASE, out_byte: '0, last: 1'b1};
                        if (emit_ready)
                        begin
                            cursor_next = step_sum[CW-1:0];
                            state_next  = S_IDLE;
                        end
                    end
                end
                else if (hit_kill)
                begin
                    state_next = cur_zero ? S_IDLE : S_KILL;
                end
                else if (hit_word)
                begin
                    phase_next   = 1'b0;
                    pending_next = 1'b0;
                    state_next   = cur_zero ? S_IDLE : S_WREAD;
                end
                else if (take_print)
                begin
                    emit = '{valid: 1'b1, action: ACT_ECHO, out_byte: byte_reg,
                             last: !wrap_full};
                    if (emit_ready)
                    begin
                        wr_en = 1'b1;
                        if (wrap_full)
                        begin
                            cursor_next = '0;
                            state_next  = S_WRAP;
                        end
                        else
                        begin
                            cursor_next = step_sum[CW-1:0];
                            state_next  = S_IDLE;
                        end
                    end
                end
                else
                begin
                    state_next = S_BELL;
                end
            end
            S_KILL:
            begin
                emit = '{valid: 1'b1, action: ACT_ERASE, out_byte: '0, last: cur_one};
                if (emit_ready)
                begin
                    cursor_next = step_sum[CW-1:0];
                    if (cur_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WREAD:
            begin
                rd_en      = 1'b1;
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                // An erase is held back until the next character shows whether
                // it is the final one of this word erase.
                if (go_on)
                begin
                    if (pending_reg)
                    begin
                        emit = '{valid: 1'b1, action: ACT_ERASE, out_byte: '0, last: 1'b0};
                    end
                    if (!pending_reg || emit_ready)
                    begin
                        cursor_next  = step_sum[CW-1:0];
                        pending_next = 1'b1;
                        phase_next   = phase_reg || not_space;
                        state_next   = cur_one ? S_WFLUSH : S_WREAD;
                    end
                end
                else
                begin
                    emit = '{valid: 1'b1, action: ACT_ERASE, out_byte: '0, last: 1'b1};
                    if (emit_ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WFLUSH:
            begin
                emit = '{valid: 1'b1, action: ACT_ERASE, out_byte: '0, last: 1'b1};
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WRAP:
            begin
                emit = '{valid: 1'b1, action: ACT_WRAP, out_byte: '0, last: 1'b1};
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BELL:
            begin
                emit = '{valid: 1'b1, action: ACT_BELL, out_byte: '0, last: 1'b1};
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cursor_reg   <= '0;
            finished_reg <= 1'b0;
            phase_reg    <= 1'b0;
            pending_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            finished_reg <= finished_next;
            phase_reg    <= phase_next;
            pending_reg  <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign status.busy     = (state_reg != S_IDLE);
    assign status.finished = finished_reg;
    assign cursor          = cursor_reg;

endmodule

FILE: rtl/core/line_edit_discipline.sv
// Top level of the canonical terminal line editor.
`timescale 1ns / 1ps

//  Channel   Direction  Signals                                  Carries
//  s_axis    in         s_tvalid s_tready s_tdata[7:0]           in_byte
//  m_axis    out        m_tvalid m_tready m_tdata[15:0] m_tlast  action, out_byte, last
//  cfg       in         cfg_valid cfg_ready cfg_index cfg_data   edit code registers
//
// A small sequencer steps one shared cursor adder over a line buffer with registered reads.
// The input is ready only between items, and a stall on m_tready holds the sequencer at its
// current action. Reset clears cursor, end flag and codes; the buffer is not cleared since
// only entries below the cursor are ever read.

module line_edit_discipline #(
    parameter int LINE_LENGTH = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] in_byte
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [2:0] action, [10:3] out_byte, [15:11] zero
    output logic        m_tlast,      // last result of this input byte
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [led_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]  cfg_data
);

    import led_pkg::*;

    localparam int CW = $clog2(LINE_LENGTH);

    led_cfg_t    cfg_reg;
    led_emit_t   emit;
    led_status_t status;
    logic        emit_ready;
    logic        wr_en, rd_en;
    logic [CW-1:0] wr_addr, rd_addr, cursor;
    logic [7:0]  wr_data, rd_data;

    logic                out_valid_reg;
    logic [ACTION_W-1:0] out_action_reg;
    logic [7:0]          out_byte_reg;
    logic                out_last_reg;

    // Edit code registers; writes to unknown indexes are dropped. Configuration is always
    // ready and is expected only while the block is idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.erase_code      <= RST_ERASE;
            cfg_reg.kill_code       <= RST_KILL;
            cfg_reg.word_erase_code <= RST_WORD;
            cfg_reg.end_code        <= RST_END;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ERASE: cfg_reg.erase_code      <= cfg_data;
                REG_KILL:  cfg_reg.kill_code       <= cfg_data;
                REG_WORD:  cfg_reg.word_erase_code <= cfg_data;
                REG_END:   cfg_reg.end_code        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    led_ctrl #(
        .LINE_LENGTH (LINE_LENGTH),
        .CW          (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .cfg        (cfg_reg),
        .emit       (emit),
        .emit_ready (emit_ready),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .status     (status),
        .cursor     (cursor)
    );

    led_line_mem #(
        .DEPTH (LINE_LENGTH),
        .AW    (CW)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: it takes a new result whenever it is empty or being drained.
    assign emit_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_ready)
        begin
            out_valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ready && emit.valid)
        begin
            out_action_reg <= emit.action;
            out_byte_reg   <= emit.out_byte;
            out_last_reg   <= emit.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_byte_reg, out_action_reg};
    assign m_tlast  = out_last_reg;

    // The sequencer never offers a result while it is ready for a new byte.
    a_no_emit_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !emit.valid)
        else $error("result offered while input ready");

    // The input is ready only while the sequencer is not busy with a byte.
    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !status.busy)
        else $error("input ready while busy");

    // Once the session has ended it stays ended.
    a_finished_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        status.finished |=> status.finished)
        else $error("end flag cleared");

    // The cursor never reaches the line length.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor) < LINE_LENGTH)
        else $error("cursor out of range");

    // A byte taken after the end yields nothing.
    a_ignored_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && status.finished) |=> !emit.valid)
        else $error("result after end of input");

endmodule

FILE: dv/tb_line_edit_discipline.sv
// Self-checking testbench of the line editing block: keystroke stimulus, display action checks.
`timescale 1ns / 1ps

module tb_line_edit_discipline;

    import led_pkg::*;

    localparam int LINE_LEN      = 40;
    localparam int IDLE_PCT      = 34;
    localparam int CALM_FROM     = 180;     // accepted keystrokes with no idling at all
    localparam int CALM_UNTIL    = 280;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 400000;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 8'd255;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [7:0]          out_byte;
        logic                last;
    } display_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]  cfg_data = 8'd0;

    line_edit_discipline #(
        .LINE_LENGTH(LINE_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Keystrokes waiting to be driven, and the display actions still owed by the block.
    logic [7:0] key_queue[$];
    display_t   due_actions[$];
    int         keys_planned = 0;
    int         keys_taken = 0;
    int         mismatches = 0;
    int         cycle_count = 0;

    // Shadow of the editor: line contents, cursor, session flag and edit codes.
    logic [7:0] typed_line [0:LINE_LEN-1];
    int         caret = 0;
    bit         session_over = 1'b0;
    led_cfg_t   codes = '{RST_ERASE, RST_KILL, RST_WORD, RST_END};

    // The newest action of a keystroke is held back so that it can carry the last flag.
    display_t   held_act;
    bit         held_valid = 1'b0;

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic void queue_action(input logic [ACTION_W-1:0] act, input logic [7:0] ch);
        if (held_valid)
            due_actions.push_back(held_act);
        held_act.action = act;
        held_act.out_byte = ch;
        held_act.last = 1'b0;
        held_valid = 1'b1;
    endfunction

    function automatic void rub_out();
        caret--;
        typed_line[caret] = 8'd0;
        queue_action(ACT_ERASE, 8'd0);
    endfunction

    // Works out the display actions of one accepted keystroke and updates the shadow line.
    // The end code only counts at column 0; elsewhere it falls through to the later checks.
    function automatic void edit_keystroke(input logic [7:0] key);
        if (session_over)
            return;
        if (key == codes.end_code && caret == 0)
        begin
            session_over = 1'b1;
            queue_action(ACT_END, 8'd0);
        end
        else if (key == codes.erase_code)
        begin
            if (caret > 0)
                rub_out();
            else
                queue_action(ACT_BELL, 8'd0);
        end
        else if (key == codes.kill_code)
        begin
            while (caret > 0)
                rub_out();
        end
        else if (key == codes.word_erase_code)
        begin
            while (caret > 0 && typed_line[caret-1] == SPACE_CHAR)
                rub_out();
            while (caret > 0 && typed_line[caret-1] != SPACE_CHAR)
                rub_out();
        end
        else if (key >= PRINT_LOW && key <= PRINT_HIGH)
        begin
            typed_line[caret] = key;
            caret++;
            queue_action(ACT_ECHO, key);
            if (caret >= LINE_LEN)
            begin
                caret = 0;
                queue_action(ACT_WRAP, 8'd0);
            end
        end
        else
        begin
            queue_action(ACT_BELL, 8'd0);
        end
        if (held_valid)
        begin
            held_act.last = 1'b1;
            due_actions.push_back(held_act);
            held_valid = 1'b0;
        end
    endfunction

    // Random idling, suspended for a stretch of keystrokes.
    function automatic bit pause_now();
        if (keys_taken >= CALM_FROM && keys_taken < CALM_UNTIL)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // Keystroke driver: valid is held until the transfer completes.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                edit_keystroke(s_tdata);
                keys_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (key_queue.size() > 0 && !pause_now())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= key_queue.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Action monitor: checks each transfer against the oldest owed action.
    always @(posedge clk)
    begin
        display_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_actions.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected action %0d byte %0d",
                                            m_tdata[2:0], m_tdata[10:3]));
                end
                else
                begin
                    want = due_actions.pop_front();
                    if (m_tdata[2:0] !== want.action)
                        note_mismatch($sformatf("action %0d, expected %0d",
                                                m_tdata[2:0], want.action));
                    if (m_tdata[10:3] !== want.out_byte)
                        note_mismatch($sformatf("out_byte %0d, expected %0d",
                                                m_tdata[10:3], want.out_byte));
                    if (m_tlast !== want.last)
                        note_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
                    if (m_tdata[15:11] !== 5'd0)
                        note_mismatch($sformatf("padding bits %b", m_tdata[15:11]));
                end
            end
            m_tready <= !pause_now();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_key(input logic [7:0] key);
        key_queue.push_back(key);
        keys_planned++;
    endtask

    // Waits until every keystroke is taken and every action has come out, then lets
    // the block finish any walk that produces no action.
    task automatic settle();
        while (keys_taken != keys_planned || due_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ERASE: codes.erase_code = val;
            REG_KILL:  codes.kill_code = val;
            REG_WORD:  codes.word_erase_code = val;
            REG_END:   codes.end_code = val;
            default:   ;
        endcase
    endtask

    task automatic write_codes(input logic [7:0] er, input logic [7:0] kl,
                               input logic [7:0] wd, input logic [7:0] en);
        write_reg(REG_ERASE, er);
        write_reg(REG_KILL, kl);
        write_reg(REG_WORD, wd);
        write_reg(REG_END, en);
    endtask

    function automatic logic [7:0] any_glyph();
        return 8'($urandom_range(33, 126));
    endfunction

    // Mostly typing of words and lines with edits in between; the end code is kept out
    // so that the session stays open until the closing phase.
    task automatic plan_random(input int target);
        int first;
        int pick;
        int count;
        logic [7:0] noise;
        first = keys_planned;
        while (keys_planned - first < target)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                count = $urandom_range(1, 8);
                repeat (count) push_key(any_glyph());
                push_key(SPACE_CHAR);
            end
            else if (pick < 50)
            begin
                // Close to a full line or more, so it often wraps.
                count = $urandom_range(35, 45);
                repeat (count)
                    push_key(($urandom_range(9) == 0) ? SPACE_CHAR : any_glyph());
            end
            else if (pick < 58)
            begin
                // Nearly full line, then one edit that clears all of it.
                push_key(codes.kill_code);
                count = $urandom_range(30, LINE_LEN - 1);
                repeat (count) push_key(any_glyph());
                push_key($urandom_range(1) ? codes.kill_code : codes.word_erase_code);
            end
            else if (pick < 70)
            begin
                count = $urandom_range(1, 3);
                repeat (count) push_key(codes.erase_code);
            end
            else if (pick < 78)
            begin
                push_key(codes.word_erase_code);
            end
            else if (pick < 84)
            begin
                push_key(codes.kill_code);
            end
            else
            begin
                noise = 8'($urandom_range(255));
                while (noise == codes.end_code)
                    noise = 8'($urandom_range(255));
                push_key(noise);
            end
        end
    endtask

    initial
    begin
        logic [7:0] er;
        logic [7:0] kl;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed keystrokes under the reset codes.
        push_key(RST_ERASE);        // erase at column 0 rings the bell
        push_key(RST_KILL);         // kill and word erase on an empty line: nothing
        push_key(RST_WORD);
        push_key(SPACE_CHAR);
        push_key(PRINT_HIGH);
        push_key("a");
        push_key(SPACE_CHAR);
        push_key("b");
        push_key(RST_END);          // end code away from column 0 rings the bell
        push_key(8'hFF);
        push_key(8'h00);
        push_key(8'h1F);
        push_key(8'h80);
        push_key(RST_WORD);         // takes the last word only
        push_key(RST_WORD);         // trailing space first, then the word before it
        push_key(RST_ERASE);
        push_key("x");
        push_key("y");
        push_key(RST_KILL);
        settle();

        // Extreme code values; spare indexes must be ignored.
        write_codes(8'd255, 8'd0, 8'd128, 8'd1);
        write_reg(REG_SPARE_LOW, 8'd9);
        write_reg(REG_SPARE_TOP, 8'd32);
        plan_random(150);
        settle();

        // Printable bytes taken over as edit codes.
        write_codes("#", "@", 8'd255, 8'd0);
        plan_random(150);
        settle();

        // Random erase and kill codes beside the other two extremes.
        er = 8'($urandom_range(1, 254));
        kl = 8'($urandom_range(1, 254));
        while (kl == er)
            kl = 8'($urandom_range(1, 254));
        write_codes(er, kl, 8'd0, 8'd255);
        plan_random(150);
        settle();

        // Back to the usual codes, then close the session and show it stays closed.
        write_codes(RST_ERASE, RST_KILL, RST_WORD, RST_END);
        push_key(RST_KILL);
        push_key("q");
        push_key("r");
        push_key(RST_END);
        push_key(RST_KILL);
        push_key(RST_END);
        push_key("z");
        push_key(RST_ERASE);
        push_key(RST_END);
        push_key(8'hFF);
        settle();

        if (due_actions.size() != 0)
            note_mismatch($sformatf("%0d actions never came out", due_actions.size()));
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/led_pkg.sv
rtl/core/led_line_mem.sv
rtl/core/led_ctrl.sv
rtl/core/line_edit_discipline.sv
dv/tb_line_edit_discipline.sv
